FILE: hw/rtl/bfte_pkg.sv
// Shared types, opcodes and sizes for the tape instruction executor.
package bfte_pkg;

   localparam int TAPE_DEPTH = 32768;
   localparam int TAPE_AW = $clog2(TAPE_DEPTH);
   localparam int TAPE_LW = TAPE_AW + 1;
   localparam int TAPE_BW = $clog2(TAPE_AW);
   localparam logic [TAPE_LW-1:0] TAPE_LEN_RESET = TAPE_LW'(30000);

   localparam int FQ_DEPTH = 2;
   localparam int FQ_AW = $clog2(FQ_DEPTH);
   localparam int RQ_DEPTH = 2;
   localparam int RQ_AW = $clog2(RQ_DEPTH);

   localparam logic [3:0] OP_RIGHT   = 4'd0;
   localparam logic [3:0] OP_LEFT    = 4'd1;
   localparam logic [3:0] OP_ADD     = 4'd2;
   localparam logic [3:0] OP_SUB     = 4'd3;
   localparam logic [3:0] OP_OUTPUT  = 4'd4;
   localparam logic [3:0] OP_INPUT   = 4'd5;
   localparam logic [3:0] OP_JZ      = 4'd6;
   localparam logic [3:0] OP_JNZ     = 4'd7;
   localparam logic [3:0] OP_END     = 4'd8;
   localparam logic [3:0] OP_COMMENT = 4'd9;

   typedef enum logic [1:0] {
      ST_RUNNING  = 2'd0,
      ST_ENDED    = 2'd1,
      ST_EOF      = 2'd2,
      ST_TOO_FAR  = 2'd3
   } bfte_status_type;

   typedef enum logic [3:0] {
      K_RIGHT, K_LEFT, K_ADD, K_SUB, K_OUT, K_IN, K_JZ, K_JNZ, K_END, K_NOP
   } bfte_kind_type;

   typedef struct packed {
      logic [3:0]  op;
      logic [15:0] pc;
      logic [15:0] operand;
      logic [7:0]  in_byte;
      logic        in_eof;
   } bfte_req_type;

   typedef struct packed {
      logic [15:0]     next_pc;
      logic            out_valid;
      logic [7:0]      out_byte;
      bfte_status_type status;
   } bfte_rsp_type;

   typedef struct packed {
      bfte_kind_type kind;
      logic [15:0]   pc;
      logic [15:0]   operand;
      logic [15:0]   pc_run;
      logic [15:0]   pc_seq;
      logic [7:0]    in_byte;
      logic          in_eof;
   } bfte_item_type;

   typedef struct packed {
      logic clearing;
      logic ptr_settled;
      logic ptr_in_range;
   } bfte_dbg_type;

endpackage

FILE: hw/rtl/bfte_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bfte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/bfte_front.sv
// Front end: accepts request transactions, decodes them and queues them for execution.
module bfte_front import bfte_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  bfte_req_type  req_data,
   input  logic          hold,
   output logic          fq_valid,
   output bfte_item_type fq_item,
   input  logic          fq_pop
);

   bfte_item_type          entry_ff [FQ_DEPTH];
   logic [FQ_AW-1:0]       wr_ptr_ff;
   logic [FQ_AW-1:0]       rd_ptr_ff;
   logic [FQ_AW:0]         count_ff;
   logic                   accept;
   logic                   take;
   bfte_item_type          decoded;

   always_comb begin
      decoded.pc      = req_data.pc;
      decoded.operand = req_data.operand;
      decoded.pc_run  = req_data.pc + req_data.operand;
      decoded.pc_seq  = req_data.pc + 16'd1;
      decoded.in_byte = req_data.in_byte;
      decoded.in_eof  = req_data.in_eof;
      unique case (req_data.op)
         OP_RIGHT:   decoded.kind = K_RIGHT;
         OP_LEFT:    decoded.kind = K_LEFT;
         OP_ADD:     decoded.kind = K_ADD;
         OP_SUB:     decoded.kind = K_SUB;
         OP_OUTPUT:  decoded.kind = K_OUT;
         OP_INPUT:   decoded.kind = K_IN;
         OP_JZ:      decoded.kind = K_JZ;
         OP_JNZ:     decoded.kind = K_JNZ;
         OP_END:     decoded.kind = K_END;
         OP_COMMENT: decoded.kind = K_NOP;
         default:    decoded.kind = K_NOP;
      endcase
   end

   assign req_full = hold || (count_ff == (FQ_AW+1)'(FQ_DEPTH));
   assign accept   = req_push && !req_full;
   assign fq_valid = (count_ff != '0);
   assign take     = fq_pop && fq_valid;
   assign fq_item  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (take) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (accept && !take) begin
            count_ff <= count_ff + 1'b1;
         end else if (take && !accept) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

FILE: hw/rtl/bfte_rspq.sv
// Result queue that holds finished transactions until the consumer pops them.
module bfte_rspq import bfte_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         rq_push,
   input  bfte_rsp_type rq_data,
   output logic         rq_full,
   input  logic         rsp_pop,
   output logic         rsp_empty,
   output bfte_rsp_type rsp_data
);

   bfte_rsp_type     entry_ff [RQ_DEPTH];
   logic [RQ_AW-1:0] wr_ptr_ff;
   logic [RQ_AW-1:0] rd_ptr_ff;
   logic [RQ_AW:0]   count_ff;
   logic             accept;
   logic             take;

   assign rq_full   = (count_ff == (RQ_AW+1)'(RQ_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign accept    = rq_push && !rq_full;
   assign take      = rsp_pop && !rsp_empty;
   assign rsp_data  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (take) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (accept && !take) begin
            count_ff <= count_ff + 1'b1;
         end else if (take && !accept) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= rq_data;
      end
   end

endmodule

FILE: hw/rtl/bfte_back.sv
// Back end: tape memory, cell pointer, length register and the execution sequencer.
module bfte_back import bfte_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [15:0]   csr_wdata,
   input  logic          fq_valid,
   input  bfte_item_type fq_item,
   output logic          fq_pop,
   output logic          clearing,
   input  logic          rq_full,
   output logic          rq_push,
   output bfte_rsp_type  rq_data,
   output bfte_dbg_type  dbg
);

   typedef enum logic [1:0] {
      S_CLEAR, S_REDUCE, S_FETCH, S_EXEC
   } state_type;

   state_type            state_ff;
   logic [TAPE_AW-1:0]   clr_addr_ff;
   logic [TAPE_AW-1:0]   ptr_ff;
   logic [TAPE_AW-1:0]   ptr_in;
   logic [TAPE_LW-1:0]   len_ff;
   logic [TAPE_LW-1:0]   len_in;
   logic                 pending_ff;
   logic                 pending_in;
   logic [TAPE_AW-1:0]   rem_ff;
   logic [TAPE_AW-1:0]   rem_in;
   logic [TAPE_LW-1:0]   rem_shift;
   logic [TAPE_BW-1:0]   bit_ff;
   bfte_item_type        item_ff;
   logic [TAPE_LW:0]     right_sum;
   logic [TAPE_LW:0]     left_sum;
   logic                 too_far;
   logic [7:0]           cell_rd;
   logic [7:0]           cell_in;
   logic                 cell_we;
   logic                 ram_we;
   logic [TAPE_AW-1:0]   ram_waddr;
   logic [7:0]           ram_wdata;
   logic                 ram_re;
   logic                 fire;

   bfte_ram #(
      .WIDTH (8),
      .DEPTH (TAPE_DEPTH)
   ) u_tape (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ptr_ff),
      .rd_data (cell_rd)
   );

   always_comb begin
      if (csr_wdata == 16'd0) begin
         len_in = TAPE_LW'(1);
      end else if (TAPE_LW'(csr_wdata) > TAPE_LW'(TAPE_DEPTH)) begin
         len_in = TAPE_LW'(TAPE_DEPTH);
      end else begin
         len_in = TAPE_LW'(csr_wdata);
      end
   end

   assign pending_in = csr_we || (pending_ff && (state_ff != S_FETCH));

   assign rem_shift = {rem_ff, ptr_ff[bit_ff]};
   assign rem_in    = (rem_shift >= len_ff) ? TAPE_AW'(rem_shift - len_ff)
                                            : TAPE_AW'(rem_shift);

   assign fq_pop   = (state_ff == S_FETCH) && !pending_ff;
   assign ram_re   = fq_pop && fq_valid;
   assign fire     = (state_ff == S_EXEC) && !rq_full;
   assign rq_push  = fire;
   assign clearing = (state_ff == S_CLEAR);

   assign right_sum = (TAPE_LW+1)'(ptr_ff) + (TAPE_LW+1)'(item_ff.operand);
   assign left_sum  = (TAPE_LW+1)'(ptr_ff) + (TAPE_LW+1)'(len_ff)
                      - (TAPE_LW+1)'(item_ff.operand);
   assign too_far   = (TAPE_LW'(item_ff.operand) >= len_ff)
                      || (item_ff.operand[15:TAPE_LW-1] != '0 && TAPE_LW < 16);

   always_comb begin
      rq_data.next_pc   = item_ff.pc_seq;
      rq_data.out_valid = 1'b0;
      rq_data.out_byte  = 8'd0;
      rq_data.status    = ST_RUNNING;
      cell_in           = cell_rd;
      cell_we           = 1'b0;
      ptr_in            = ptr_ff;
      case (item_ff.kind) inside
         K_RIGHT, K_LEFT: begin
            if (too_far) begin
               rq_data.next_pc = item_ff.pc;
               rq_data.status  = ST_TOO_FAR;
            end else begin
               rq_data.next_pc = item_ff.pc_run;
               if (item_ff.kind == K_RIGHT) begin
                  ptr_in = (right_sum >= (TAPE_LW+1)'(len_ff))
                           ? TAPE_AW'(right_sum - (TAPE_LW+1)'(len_ff))
                           : TAPE_AW'(right_sum);
               end else if (item_ff.operand <= 16'(ptr_ff)) begin
                  ptr_in = TAPE_AW'(16'(ptr_ff) - item_ff.operand);
               end else begin
                  ptr_in = TAPE_AW'(left_sum);
               end
            end
         end
         K_ADD: begin
            rq_data.next_pc = item_ff.pc_run;
            cell_in         = cell_rd + item_ff.operand[7:0];
            cell_we         = 1'b1;
         end
         K_SUB: begin
            rq_data.next_pc = item_ff.pc_run;
            cell_in         = cell_rd - item_ff.operand[7:0];
            cell_we         = 1'b1;
         end
         K_OUT: begin
            rq_data.out_valid = 1'b1;
            rq_data.out_byte  = cell_rd;
         end
         K_IN: begin
            if (item_ff.in_eof) begin
               rq_data.next_pc = item_ff.pc;
               rq_data.status  = ST_EOF;
            end else begin
               cell_in = item_ff.in_byte;
               cell_we = 1'b1;
            end
         end
         K_JZ: begin
            if (cell_rd == 8'd0) begin
               rq_data.next_pc = item_ff.operand;
            end
         end
         K_JNZ: begin
            if (cell_rd != 8'd0) begin
               rq_data.next_pc = item_ff.operand;
            end
         end
         K_END: begin
            rq_data.next_pc = item_ff.pc;
            rq_data.status  = ST_ENDED;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (state_ff == S_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = 8'd0;
      end else begin
         ram_we    = fire && cell_we;
         ram_waddr = ptr_ff;
         ram_wdata = cell_in;
      end
   end

   assign dbg.clearing     = clearing;
   assign dbg.ptr_settled  = !pending_ff && (state_ff != S_REDUCE);
   assign dbg.ptr_in_range = (TAPE_LW'(ptr_ff) < len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_addr_ff <= '0;
         ptr_ff      <= '0;
         len_ff      <= TAPE_LEN_RESET;
         pending_ff  <= 1'b0;
         rem_ff      <= '0;
         bit_ff      <= '0;
      end else begin
         pending_ff <= pending_in;
         if (csr_we) begin
            len_ff <= len_in;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == TAPE_AW'(TAPE_DEPTH - 1)) begin
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               if (pending_ff) begin
                  state_ff <= S_REDUCE;
                  rem_ff   <= '0;
                  bit_ff   <= TAPE_BW'(TAPE_AW - 1);
               end else if (fq_valid) begin
                  state_ff <= S_EXEC;
                  item_ff  <= fq_item;
               end
            end
            S_REDUCE: begin
               rem_ff <= rem_in;
               bit_ff <= bit_ff - 1'b1;
               if (bit_ff == '0) begin
                  ptr_ff   <= rem_in;
                  state_ff <= S_FETCH;
               end
            end
            S_EXEC: begin
               if (fire) begin
                  ptr_ff   <= ptr_in;
                  state_ff <= S_FETCH;
               end
            end
            default: begin
               state_ff <= S_FETCH;
            end
         endcase
      end
   end

endmodule

FILE: hw/rtl/bf_tape_instruction_executor_unit.sv
// Top level of the tape instruction executor: front end, back end and result queue.
// A request transaction passes through the front queue, the back end fetch and execute states
// and the result queue, where it waits while rsp_pop is low.
// The back end works on one transaction at a time, a tape RAM read then a write per item.
// Reset: synchronous; afterwards a clearing pass zeroes all 32768 tape cells with req_full high.
// A tape length write starts a bitwise pointer reduction modulo the new length that runs before the next item.
module bf_tape_instruction_executor_unit import bfte_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  bfte_req_type req_data,
   input  logic         rsp_pop,
   output logic         rsp_empty,
   output bfte_rsp_type rsp_data,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata
);

   logic          fq_valid;
   bfte_item_type fq_item;
   logic          fq_pop;
   logic          clearing;
   logic          rq_full;
   logic          rq_push;
   bfte_rsp_type  rq_data;
   bfte_dbg_type  dbg;

   bfte_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .hold     (clearing),
      .fq_valid (fq_valid),
      .fq_item  (fq_item),
      .fq_pop   (fq_pop)
   );

   bfte_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .fq_valid  (fq_valid),
      .fq_item   (fq_item),
      .fq_pop    (fq_pop),
      .clearing  (clearing),
      .rq_full   (rq_full),
      .rq_push   (rq_push),
      .rq_data   (rq_data),
      .dbg       (dbg)
   );

   bfte_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .rq_push   (rq_push),
      .rq_data   (rq_data),
      .rq_full   (rq_full),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   // No request transaction may enter while the tape is being cleared.
   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      dbg.clearing |-> req_full)
      else $error("request accepted during tape clearing");

   // The back end never pushes into a full result queue.
   a_no_result_overflow: assert property (@(posedge clock) disable iff (reset)
      rq_push |-> !rq_full)
      else $error("result pushed into a full queue");

   // Once no length update is outstanding, the pointer lies inside the tape.
   a_pointer_in_range: assert property (@(posedge clock) disable iff (reset)
      dbg.ptr_settled |-> dbg.ptr_in_range)
      else $error("cell pointer outside tape length");

endmodule

FILE: tb/tb_bf_tape_instruction_executor_unit.sv
// Self-checking testbench for the tape instruction executor with a built-in tape predictor.
`timescale 1ns / 100ps

module tb_bf_tape_instruction_executor_unit;
   import bfte_pkg::*;

   localparam int STALL_LIMIT = 100000;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_push = 1'b0;
   logic         req_full;
   bfte_req_type req_data = '0;
   logic         rsp_pop = 1'b0;
   logic         rsp_empty;
   bfte_rsp_type rsp_data;
   logic         csr_we = 1'b0;
   logic [15:0]  csr_wdata = '0;

   logic [7:0]   tape_img [0:TAPE_DEPTH-1];
   int unsigned  cell_ptr;
   logic [15:0]  tape_len_reg;
   bfte_rsp_type pending_results [$];
   int           mismatch_count = 0;
   int           stall_cycles = 0;
   int           idle_pct = 0;
   int           pop_hold = 0;

   bf_tape_instruction_executor_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic int unsigned effective_len(input logic [15:0] value);
      if (value == 16'd0) return 1;
      if (32'(value) > TAPE_DEPTH) return TAPE_DEPTH;
      return 32'(value);
   endfunction

   function automatic bfte_rsp_type execute_item(input bfte_req_type r);
      bfte_rsp_type res;
      int unsigned  len;
      int unsigned  cnt;
      len = effective_len(tape_len_reg);
      cnt = 32'(r.operand);
      cell_ptr = cell_ptr % len;
      res.next_pc = r.pc + 16'd1;
      res.out_valid = 1'b0;
      res.out_byte = 8'd0;
      res.status = ST_RUNNING;
      case (r.op) inside
         OP_RIGHT, OP_LEFT: begin
            if (cnt >= len) begin
               res.next_pc = r.pc;
               res.status = ST_TOO_FAR;
            end else begin
               if (r.op == OP_RIGHT) cell_ptr = (cell_ptr + cnt) % len;
               else cell_ptr = (cell_ptr + len - cnt) % len;
               res.next_pc = r.pc + r.operand;
            end
         end
         OP_ADD: begin
            tape_img[cell_ptr] = tape_img[cell_ptr] + r.operand[7:0];
            res.next_pc = r.pc + r.operand;
         end
         OP_SUB: begin
            tape_img[cell_ptr] = tape_img[cell_ptr] - r.operand[7:0];
            res.next_pc = r.pc + r.operand;
         end
         OP_OUTPUT: begin
            res.out_valid = 1'b1;
            res.out_byte = tape_img[cell_ptr];
         end
         OP_INPUT: begin
            if (r.in_eof) begin
               res.next_pc = r.pc;
               res.status = ST_EOF;
            end else begin
               tape_img[cell_ptr] = r.in_byte;
            end
         end
         OP_JZ: if (tape_img[cell_ptr] == 8'd0) res.next_pc = r.operand;
         OP_JNZ: if (tape_img[cell_ptr] != 8'd0) res.next_pc = r.operand;
         OP_END: begin
            res.next_pc = r.pc;
            res.status = ST_ENDED;
         end
         default: ;
      endcase
      return res;
   endfunction

   // Prediction, result checking and the watchdog share one process so that
   // the order in which their events run cannot matter.
   always @(posedge clock) begin : monitor
      bfte_rsp_type want;
      if (reset) begin
         for (int i = 0; i < TAPE_DEPTH; i++) tape_img[i] = 8'd0;
         cell_ptr = 0;
         tape_len_reg = TAPE_LEN_RESET[15:0];
         stall_cycles = 0;
      end else begin
         if (csr_we) tape_len_reg = csr_wdata;
         if (req_push && !req_full) pending_results.push_back(execute_item(req_data));
         if (rsp_pop && !rsp_empty) begin
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected transaction next_pc=%h valid=%b byte=%h status=%0d",
                           $time, rsp_data.next_pc, rsp_data.out_valid, rsp_data.out_byte,
                           rsp_data.status);
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.next_pc !== want.next_pc || rsp_data.out_valid !== want.out_valid ||
                   rsp_data.out_byte !== want.out_byte || rsp_data.status !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: expected next_pc=%h valid=%b byte=%h status=%0d, %s%h %s%b %s%h %s%0d",
                              $time, want.next_pc, want.out_valid, want.out_byte, want.status,
                              "got next_pc=", rsp_data.next_pc, "valid=", rsp_data.out_valid,
                              "byte=", rsp_data.out_byte, "status=", rsp_data.status);
               end
            end
         end
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (pop_hold == 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
         pop_hold = $urandom_range(1, 3);
      if (pop_hold > 0) begin
         rsp_pop <= 1'b0;
         pop_hold--;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   function automatic bfte_req_type make_req(input logic [3:0] op, input logic [15:0] pc,
                                             input logic [15:0] operand,
                                             input logic [7:0] in_byte = 8'd0,
                                             input logic in_eof = 1'b0);
      bfte_req_type r;
      r.op = op;
      r.pc = pc;
      r.operand = operand;
      r.in_byte = in_byte;
      r.in_eof = in_eof;
      return r;
   endfunction

   task automatic send_item(input bfte_req_type item);
      @(negedge clock);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_data <= item;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_tape_length(input logic [15:0] value);
      wait_drained();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic test_basic_ops();
      send_item(make_req(OP_ADD, 16'h0000, 16'hFFFF));
      send_item(make_req(OP_OUTPUT, 16'hFFFF, 16'h0000));
      send_item(make_req(OP_SUB, 16'h000A, 16'h0100));
      send_item(make_req(OP_SUB, 16'h0001, 16'h0000));
      send_item(make_req(OP_JNZ, 16'h0005, 16'hABCD));
      send_item(make_req(OP_JZ, 16'h0005, 16'h1234));
      send_item(make_req(OP_INPUT, 16'h0006, 16'h0000, 8'h00, 1'b0));
      send_item(make_req(OP_JZ, 16'h0007, 16'h5432));
      send_item(make_req(OP_INPUT, 16'h0008, 16'hFFFF, 8'hFF, 1'b1));
      send_item(make_req(OP_OUTPUT, 16'h0009, 16'h0000));
      send_item(make_req(OP_END, 16'h1234, 16'h0000));
      send_item(make_req(OP_COMMENT, 16'hFFFF, 16'hFFFF));
      send_item(make_req(4'd10, 16'h0020, 16'h0000));
      send_item(make_req(4'd15, 16'h0021, 16'hFFFF, 8'hFF, 1'b1));
   endtask

   task automatic test_moves_and_lengths();
      send_item(make_req(OP_LEFT, 16'h0100, 16'd1));
      send_item(make_req(OP_ADD, 16'h0101, 16'd3));
      send_item(make_req(OP_RIGHT, 16'h0102, 16'd1));
      send_item(make_req(OP_RIGHT, 16'h0103, 16'd30000));
      send_item(make_req(OP_RIGHT, 16'h0104, 16'd29999));
      send_item(make_req(OP_OUTPUT, 16'h0105, 16'd0));
      write_tape_length(16'hFFFF);
      send_item(make_req(OP_RIGHT, 16'h0200, 16'd32768));
      send_item(make_req(OP_LEFT, 16'h0201, 16'd32767));
      write_tape_length(16'd0);
      send_item(make_req(OP_OUTPUT, 16'h0300, 16'd0));
      send_item(make_req(OP_RIGHT, 16'h0301, 16'd1));
      send_item(make_req(OP_LEFT, 16'h0302, 16'd0));
   endtask

   function automatic bfte_req_type random_instr(input int unsigned len);
      bfte_req_type r;
      r.pc = 16'($urandom);
      r.in_byte = 8'($urandom);
      r.in_eof = ($urandom_range(0, 6) == 0);
      r.operand = 16'($urandom);
      if ($urandom_range(0, 9) == 0) begin
         r.op = 4'($urandom_range(0, 15));
         return r;
      end
      case ($urandom_range(0, 11)) inside
         [0:3]: begin
            r.op = $urandom_range(0, 1) ? OP_RIGHT : OP_LEFT;
            if ($urandom_range(0, 7) == 0) r.operand = 16'($urandom_range(len, 65535));
            else r.operand = 16'($urandom_range(0, len - 1));
         end
         4: begin
            r.op = OP_ADD;
            if ($urandom_range(0, 1)) r.operand = 16'($urandom_range(0, 3));
         end
         5: begin
            r.op = OP_SUB;
            if ($urandom_range(0, 1)) r.operand = 16'($urandom_range(0, 3));
         end
         [6:7]: r.op = OP_OUTPUT;
         8: r.op = OP_INPUT;
         9: r.op = OP_JZ;
         10: r.op = OP_JNZ;
         default: r.op = ($urandom_range(0, 3) == 0) ? OP_END : OP_INPUT;
      endcase
      return r;
   endfunction

   task automatic test_random_programs();
      logic [15:0]  len_val;
      int           useful;
      bfte_req_type r;
      for (int phase = 0; phase < 14; phase++) begin
         case (phase)
            0: len_val = 16'd32768;
            1: len_val = 16'd1;
            2: len_val = 16'd16;
            3: len_val = 16'hFFFF;
            default: begin
               case ($urandom_range(0, 7))
                  0: len_val = 16'd0;
                  1: len_val = 16'($urandom);
                  2: len_val = 16'($urandom_range(TAPE_DEPTH - 4, TAPE_DEPTH));
                  default: len_val = 16'($urandom_range(2, 40));
               endcase
            end
         endcase
         write_tape_length(len_val);
         idle_pct = (phase % 3 == 0) ? 0 : $urandom_range(10, 35);
         useful = 0;
         while (useful < 46) begin
            r = random_instr(effective_len(len_val));
            send_item(r);
            if (r.op <= OP_END) useful++;
         end
      end
   endtask

   task automatic test_streaming();
      bfte_req_type r;
      write_tape_length(16'd8);
      idle_pct = 0;
      for (int i = 0; i < 60; i++) begin
         r = random_instr(8);
         send_item(r);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_ops();
      test_moves_and_lengths();
      test_random_programs();
      test_streaming();
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/bfte_pkg.sv
hw/rtl/bfte_ram.sv
hw/rtl/bfte_front.sv
hw/rtl/bfte_rspq.sv
hw/rtl/bfte_back.sv
hw/rtl/bf_tape_instruction_executor_unit.sv
tb/tb_bf_tape_instruction_executor_unit.sv
